[rtl/core/awde_pkg.sv]
// ============================================================================
// awde_pkg: shared types and constants of the adaptive width delta encoder
// Holds the code width ladder, its rung helpers and the packing widths.
// ============================================================================
package awde_pkg;

    typedef logic [4:0] width_t;

    localparam int CODE_W = 17;
    localparam int ACC_W  = 24;
    localparam int CNT_W  = 5;

    localparam logic REG_START_WIDTH = 1'b0;
    localparam logic REG_MAX_WIDTH   = 1'b1;

    function automatic logic is_rung(input width_t w);
        return w inside {5'd1, 5'd2, 5'd3, 5'd6, 5'd11, 5'd17};
    endfunction

    function automatic width_t rung_up(input width_t w);
        width_t r;
        case (w)
            5'd1:    r = 5'd2;
            5'd2:    r = 5'd3;
            5'd3:    r = 5'd6;
            5'd6:    r = 5'd11;
            5'd11:   r = 5'd17;
            default: r = 5'd17;
        endcase
        return r;
    endfunction

    function automatic width_t rung_down(input width_t w);
        width_t r;
        case (w)
            5'd2:    r = 5'd1;
            5'd3:    r = 5'd2;
            5'd6:    r = 5'd3;
            5'd11:   r = 5'd6;
            5'd17:   r = 5'd11;
            default: r = 5'd1;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/adaptive_width_delta_encoder_core.sv]
// ============================================================================
// adaptive_width_delta_encoder_core: delta encoder with adaptive code width
// Codes sample differences on a width ladder with escapes and packs the
// codes into bytes, padding each block to a multiple of four bytes.
// ============================================================================
// Usage:
//   Input channel (sample, block_last) and output channel (out_byte, error,
//   run_last, block_end) use valid/stall. in_stall is high while an item is
//   being worked on; one item is taken at a time.
//   Each item runs through subtract, fit and pack logic under a small
//   sequencer: accept, delta, check, then one code pass (code, emit) per
//   escape plus the final code, with each byte produced sent out in the
//   emit state, and a closing state. A block end adds a flush state that
//   sends out the flush and pad bytes before the closing state.
//   Bytes go through a one-byte hold stage so run_last can be set on the
//   last byte of an item; the output register lets the next item start
//   while a result waits.
//   A stall on the output freezes the sequencer only when a new byte has no
//   room; out_* hold while stalled.
//   Reset clears all control state, loads start_width 3 and max_width 17.
//   After an error result every further item is dropped until reset.
//   cfg_we writes register cfg_index (0: start_width, 1: max_width) at once.
// ============================================================================
module adaptive_width_delta_encoder_core #(
    parameter int SAMPLE_WIDTH = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  awde_pkg::width_t               cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           block_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           error,
    output logic                           run_last,
    output logic                           block_end
);
    import awde_pkg::*;

    localparam int DW = SAMPLE_WIDTH + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELTA = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_CODE  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    function automatic logic fits(input logic signed [DW-1:0] d, input width_t w,
                                  input logic at_top);
        width_t                sh;
        logic signed [DW-1:0]  hi;
        logic        [DW-1:0]  low_mask;
        logic                  low_nz;
        sh       = w - 5'd1;
        hi       = d >>> sh;
        low_mask = ~({DW{1'b1}} << sh);
        low_nz   = |(d & low_mask);
        return (hi == '0) || ((hi == '1) && (at_top || low_nz));
    endfunction

    logic [2:0]                    state_reg, state_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg, sample_next;
    logic                          last_reg, last_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_reg, prev_next;
    logic signed [DW-1:0]          delta_reg, delta_next;
    width_t                        start_w_reg, start_w_next;
    width_t                        max_w_reg, max_w_next;
    width_t                        cur_w_reg, cur_w_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [1:0]                    phase_reg, phase_next;
    logic                          sticky_reg, sticky_next;
    logic                          done_reg, done_next;
    logic                          hold_valid_reg, hold_valid_next;
    logic [7:0]                    hold_byte_reg, hold_byte_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg, out_byte_next;
    logic                          out_error_reg, out_error_next;
    logic                          out_run_last_reg, out_run_last_next;
    logic                          out_block_end_reg, out_block_end_next;

    logic                          out_free;
    logic                          can_push;
    logic                          push;
    logic [7:0]                    push_byte;
    logic                          cfg_ok;
    logic                          fit_cur;
    logic                          fit_down;
    logic signed [CODE_W+DW-1:0]   dext;
    logic [CODE_W-1:0]             code;
    logic [CODE_W-1:0]             code_mask;

    assign out_free = !out_valid_reg || !out_stall;
    assign can_push = !hold_valid_reg || out_free;
    assign cfg_ok   = is_rung(start_w_reg) && is_rung(max_w_reg) &&
                      (start_w_reg <= max_w_reg) && is_rung(cur_w_reg) &&
                      (cur_w_reg <= max_w_reg);
    assign fit_cur  = fits(delta_reg, cur_w_reg, cur_w_reg == max_w_reg);
    assign fit_down = fits(delta_reg, rung_down(cur_w_reg), 1'b0);
    assign dext     = (CODE_W+DW)'(delta_reg);
    assign code_mask = {CODE_W{1'b1}} >> (5'(CODE_W) - cur_w_reg);
    assign code     = fit_cur ? dext[CODE_W-1:0]
                              : (CODE_W'(1) << (cur_w_reg - 5'd1));

    always_comb
    begin
        state_next         = state_reg;
        sample_next        = sample_reg;
        last_next          = last_reg;
        prev_next          = prev_reg;
        delta_next         = delta_reg;
        start_w_next       = start_w_reg;
        max_w_next         = max_w_reg;
        cur_w_next         = cur_w_reg;
        acc_next           = acc_reg;
        cnt_next           = cnt_reg;
        phase_next         = phase_reg;
        sticky_next        = sticky_reg;
        done_next          = done_reg;
        hold_valid_next    = hold_valid_reg;
        hold_byte_next     = hold_byte_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_byte_next      = out_byte_reg;
        out_error_next     = out_error_reg;
        out_run_last_next  = out_run_last_reg;
        out_block_end_next = out_block_end_reg;
        push               = 1'b0;
        push_byte          = 8'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !sticky_reg)
                begin
                    sample_next = sample;
                    last_next   = block_last;
                    state_next  = S_DELTA;
                end
            end
            S_DELTA:
            begin
                delta_next = DW'(sample_reg) - DW'(prev_reg);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!cfg_ok || !fits(delta_reg, max_w_reg, 1'b1))
                begin
                    if (out_free)
                    begin
                        out_valid_next     = 1'b1;
                        out_byte_next      = 8'd0;
                        out_error_next     = 1'b1;
                        out_run_last_next  = 1'b1;
                        out_block_end_next = 1'b0;
                        sticky_next        = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_CODE;
                end
            end
            S_CODE:
            begin
                acc_next = acc_reg | (ACC_W'(code & code_mask) << cnt_reg[2:0]);
                cnt_next = cnt_reg + cur_w_reg;
                if (fit_cur)
                begin
                    done_next = 1'b1;
                    if (cur_w_reg != 5'd1 && fit_down)
                    begin
                        cur_w_next = rung_down(cur_w_reg);
                    end
                end
                else
                begin
                    done_next  = 1'b0;
                    cur_w_next = rung_up(cur_w_reg);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (cnt_reg >= CNT_W'(8))
                begin
                    if (can_push)
                    begin
                        push       = 1'b1;
                        push_byte  = acc_reg[7:0];
                        acc_next   = acc_reg >> 8;
                        cnt_next   = cnt_reg - CNT_W'(8);
                        phase_next = phase_reg + 2'd1;
                    end
                end
                else if (!done_reg)
                begin
                    state_next = S_CODE;
                end
                else if (last_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FLUSH:
            begin
                if (cnt_reg != '0 || phase_reg != 2'd0)
                begin
                    if (can_push)
                    begin
                        push       = 1'b1;
                        push_byte  = acc_reg[7:0];
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = phase_reg + 2'd1;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next     = 1'b1;
                        out_byte_next      = hold_byte_reg;
                        out_error_next     = 1'b0;
                        out_run_last_next  = 1'b1;
                        out_block_end_next = last_reg;
                        hold_valid_next    = 1'b0;
                    end
                    if (last_reg)
                    begin
                        prev_next  = '0;
                        cur_w_next = start_w_reg;
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = 2'd0;
                    end
                    else
                    begin
                        prev_next = sample_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Advance the hold stage: the older byte leaves, the new one waits.
        if (push)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next     = 1'b1;
                out_byte_next      = hold_byte_reg;
                out_error_next     = 1'b0;
                out_run_last_next  = 1'b0;
                out_block_end_next = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = push_byte;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_START_WIDTH:
                begin
                    start_w_next = cfg_data;
                    cur_w_next   = cfg_data;
                end
                REG_MAX_WIDTH:
                begin
                    max_w_next = cfg_data;
                end
                default:
                begin
                    max_w_next = max_w_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            last_reg          <= 1'b0;
            prev_reg          <= '0;
            start_w_reg       <= 5'd3;
            max_w_reg         <= 5'd17;
            cur_w_reg         <= 5'd3;
            acc_reg           <= '0;
            cnt_reg           <= '0;
            phase_reg         <= 2'd0;
            sticky_reg        <= 1'b0;
            done_reg          <= 1'b0;
            hold_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_error_reg     <= 1'b0;
            out_run_last_reg  <= 1'b0;
            out_block_end_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            last_reg          <= last_next;
            prev_reg          <= prev_next;
            start_w_reg       <= start_w_next;
            max_w_reg         <= max_w_next;
            cur_w_reg         <= cur_w_next;
            acc_reg           <= acc_next;
            cnt_reg           <= cnt_next;
            phase_reg         <= phase_next;
            sticky_reg        <= sticky_next;
            done_reg          <= done_next;
            hold_valid_reg    <= hold_valid_next;
            out_valid_reg     <= out_valid_next;
            out_error_reg     <= out_error_next;
            out_run_last_reg  <= out_run_last_next;
            out_block_end_reg <= out_block_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        delta_reg     <= delta_next;
        hold_byte_reg <= hold_byte_next;
        out_byte_reg  <= out_byte_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign error     = out_error_reg;
    assign run_last  = out_run_last_reg;
    assign block_end = out_block_end_reg;

    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(sticky_reg))
        else $error("sticky error cleared without reset");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !hold_valid_reg && cnt_reg < CNT_W'(8))
        else $error("idle with a held byte or a full byte pending");

    a_block_closed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && $past(state_reg) == S_FIN && $past(last_reg)
        |-> phase_reg == 2'd0 && cnt_reg == '0)
        else $error("block closed off a four byte boundary");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_error_reg |-> out_run_last_reg && !out_block_end_reg
                                            && out_byte_reg == 8'd0)
        else $error("malformed error item");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_block_end_reg |-> out_run_last_reg)
        else $error("block end without run last");

endmodule
